@@ hw/rtl/fhcf_pkg.sv @@
// shared types and constants for the fog height crossing fraction block
package fhcf_pkg;

   localparam int CfgWidth = 7;

   typedef enum logic [0:0] {
      CSR_RAMP_RANGE = 1'b0,
      CSR_DEEP_DEPTH = 1'b1
   } csr_index_type;

   localparam logic [CfgWidth-1:0] RAMP_RANGE_RESET = 7'd8;
   localparam logic [CfgWidth-1:0] DEEP_DEPTH_RESET = 7'd30;

   // which rule settles an item
   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_FULL  = 2'd1,
      KIND_FLAT  = 2'd2,
      KIND_SPAN  = 2'd3
   } kind_type;

endpackage

@@ hw/rtl/fog_height_crossing_fraction.sv @@
// Fog fraction of a vertical path between a view height and a target height, as alpha.
// The block takes one height pair per cycle while req_stall is low and holds each alpha
// at the output until taken. There are thirteen register stages: five arithmetic stages
// (classify, products, clamp, wide products, numerator) followed by an eight-stage
// restoring divider that resolves one quotient bit per stage. The pipeline moves as a
// whole whenever the output register is empty or being taken, so req_stall follows
// rsp_stall only while a result is held at the output. Registers are to be written via
// csr_* only while no item is in flight (not enforced); a zero in either acts as one.
module fog_height_crossing_fraction
   import fhcf_pkg::*;
#(
   parameter int HEIGHT_BITS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [HEIGHT_BITS-1:0] req_view_height,
   input  logic signed [HEIGHT_BITS-1:0] req_target_height,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_fog_alpha,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [CfgWidth-1:0]           csr_data
);

   localparam int H    = HEIGHT_BITS;
   localparam int RF   = CfgWidth + FRAC_BITS;          // ramp or depth in height units
   localparam int SW   = ((H > RF + 1) ? H : RF + 1) + 2;
   localparam int P1W  = RF + 1 + H;
   localparam int P2W  = 2 * SW;
   localparam int DFW  = 2 * SW + 1;
   localparam int DENW = RF + 1 + H;
   localparam int AW   = RF + DENW;
   localparam int NW   = AW + 9;
   localparam int QB   = 8;

   // configuration
   logic [CfgWidth-1:0] ramp_ff, deep_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= RAMP_RANGE_RESET;
         deep_ff <= DEEP_DEPTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RAMP_RANGE: ramp_ff <= csr_data;
            CSR_DEEP_DEPTH: deep_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // the whole pipe steps together
   logic adv;
   logic [4:0] vld_ff;
   logic [QB-1:0] dvld_ff;

   assign adv       = !dvld_ff[QB-1] || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         dvld_ff <= '0;
      end else if (adv) begin
         vld_ff  <= {vld_ff[3:0], req_valid};
         dvld_ff <= {dvld_ff[QB-2:0], vld_ff[4]};
      end
   end

   // stage 1: classify
   logic [CfgWidth-1:0] ramp_eff, deep_eff;
   logic [RF-1:0] rf_u, df_u;
   logic signed [SW-1:0] v_s, t_s, rf_s, df_s, hi_s, lo_s, top_s, bot_s;
   kind_type kind_in;

   assign ramp_eff = (ramp_ff == '0) ? CfgWidth'(1) : ramp_ff;
   assign deep_eff = (deep_ff == '0) ? CfgWidth'(1) : deep_ff;
   assign rf_u = RF'(ramp_eff) << FRAC_BITS;
   assign df_u = RF'(deep_eff) << FRAC_BITS;
   assign rf_s = $signed(SW'(rf_u));
   assign df_s = $signed(SW'(df_u));
   assign v_s  = SW'(req_view_height);
   assign t_s  = SW'(req_target_height);
   assign hi_s = (v_s > t_s) ? v_s : t_s;
   assign lo_s = (v_s > t_s) ? t_s : v_s;
   assign top_s = (hi_s > 0) ? '0 : hi_s;
   assign bot_s = (lo_s < -rf_s) ? -rf_s : lo_s;

   always_comb begin
      if (v_s > 0 && t_s > 0)
         kind_in = KIND_CLEAR;
      else if (v_s < -rf_s && t_s < -rf_s)
         kind_in = KIND_FULL;
      else if (v_s == t_s)
         kind_in = KIND_FLAT;
      else if (lo_s <= -df_s)
         kind_in = KIND_FULL;
      else
         kind_in = KIND_SPAN;
   end

   kind_type kind1_ff, kind2_ff, kind3_ff, kind4_ff;
   logic [H-1:0] a1_ff, tot1_ff;
   logic signed [SW-1:0] b1_ff, c1_ff, m1_ff;
   logic [RF-1:0] rf1_ff, df1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff <= kind_in;
         a1_ff    <= H'(top_s - lo_s);
         b1_ff    <= top_s - bot_s;
         c1_ff    <= rf_s + rf_s + top_s + bot_s;
         tot1_ff  <= H'(hi_s - lo_s);
         m1_ff    <= -lo_s;
         rf1_ff   <= rf_u;
         df1_ff   <= df_u;
      end
   end

   // stage 2: first products
   logic [RF:0] rf2;
   logic [P1W-1:0] p1_ff;
   logic signed [P2W-1:0] p2_ff;
   logic [DENW-1:0] den2_ff;
   logic [RF-1:0] m2_ff, dm2_ff, df2_ff, rf2_ff;

   assign rf2 = {rf1_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff <= kind1_ff;
         p1_ff    <= P1W'(rf2) * P1W'(a1_ff);
         p2_ff    <= P2W'(b1_ff) * P2W'(c1_ff);
         den2_ff  <= DENW'(rf2) * DENW'(tot1_ff);
         m2_ff    <= RF'(m1_ff);
         dm2_ff   <= df1_ff - RF'(m1_ff);
         df2_ff   <= df1_ff;
         rf2_ff   <= rf1_ff;
      end
   end

   // stage 3: numerator of the path share, clamped at zero
   logic signed [DFW-1:0] diff;
   logic [DENW-1:0] num3_ff, den3_ff;
   logic [RF-1:0] m3_ff, dm3_ff, df3_ff, rf3_ff;

   assign diff = $signed(DFW'(p1_ff)) - DFW'(p2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         kind3_ff <= kind2_ff;
         num3_ff  <= diff[DFW-1] ? '0 : DENW'(diff);
         den3_ff  <= den2_ff;
         m3_ff    <= m2_ff;
         dm3_ff   <= dm2_ff;
         df3_ff   <= df2_ff;
         rf3_ff   <= rf2_ff;
      end
   end

   // stage 4: depth blend folded into one quotient
   logic [AW-1:0] x4_ff, y4_ff, dd4_ff;
   logic [RF-1:0] m4_ff, rf4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kind4_ff <= kind3_ff;
         x4_ff    <= AW'(m3_ff) * AW'(den3_ff);
         y4_ff    <= AW'(dm3_ff) * AW'(num3_ff);
         dd4_ff   <= AW'(den3_ff) * AW'(df3_ff);
         m4_ff    <= m3_ff;
         rf4_ff   <= rf3_ff;
      end
   end

   // stage 5: dividend and divisor per rule
   logic [AW:0] sum5;
   logic [NW-1:0] n_in;
   logic [AW-1:0] d_in;

   assign sum5 = (AW + 1)'(x4_ff) + (AW + 1)'(y4_ff);

   always_comb begin
      case (kind4_ff)
         KIND_CLEAR: begin
            n_in = '0;
            d_in = AW'(1);
         end
         KIND_FULL: begin
            n_in = NW'(255);
            d_in = AW'(1);
         end
         KIND_FLAT: begin
            n_in = (NW'(m4_ff) << 8) - NW'(m4_ff);
            d_in = AW'(rf4_ff);
         end
         default: begin
            n_in = (NW'(sum5) << 8) - NW'(sum5);
            d_in = dd4_ff;
         end
      endcase
   end

   logic [NW-1:0] n5_ff;
   logic [AW-1:0] d5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         n5_ff <= n_in;
         d5_ff <= d_in;
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   logic [NW-1:0] rem_ff [QB];
   logic [AW-1:0] dv_ff  [QB];
   logic [QB-1:0] q_ff   [QB];

   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [NW-1:0] rem_src, trial;
      logic [AW-1:0] dv_src;
      logic [QB-1:0] q_src;
      logic take;

      if (j == 0) begin : g_first
         assign rem_src = n5_ff;
         assign dv_src  = d5_ff;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign dv_src  = dv_ff[j-1];
         assign q_src   = q_ff[j-1];
      end

      assign trial = NW'(dv_src) << (QB - 1 - j);
      assign take  = rem_src >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= take ? rem_src - trial : rem_src;
            dv_ff[j]  <= dv_src;
            q_ff[j]   <= {q_src[QB-2:0], take};
         end
      end
   end

   assign rsp_valid     = dvld_ff[QB-1];
   assign rsp_fog_alpha = q_ff[QB-1];

endmodule

@@ test/tb.sv @@
// testbench for the fog height crossing fraction block: predicted alpha checked per item
`timescale 1ns / 100ps

module tb;
   import fhcf_pkg::*;

   class alpha_scoreboard;
      logic [7:0] pending[$];
      int         errors;
      logic [6:0] ramp_reg;
      logic [6:0] deep_reg;

      function new();
         errors   = 0;
         ramp_reg = RAMP_RANGE_RESET;
         deep_reg = DEEP_DEPTH_RESET;
      endfunction

      function logic [7:0] fog_alpha_of(logic signed [15:0] vh, logic signed [15:0] th);
         longint    v, t, rf, df, a, hi_h, lo_h, total, m, top, bot, num;
         bit [127:0] prod;
         longint unsigned den, k, q;
         v  = vh;
         t  = th;
         rf = longint'(ramp_reg == 0 ? 1 : ramp_reg) << 8;
         df = longint'(deep_reg == 0 ? 1 : deep_reg) << 8;
         if (v > 0 && t > 0) begin
            a = 0;
         end else if (v < -rf && t < -rf) begin
            a = 255;
         end else begin
            hi_h  = v > t ? v : t;
            lo_h  = v > t ? t : v;
            total = hi_h - lo_h;
            if (total == 0) begin
               a = (255 * (-v)) / rf;
            end else begin
               m = -lo_h;
               if (m >= df) begin
                  a = 255;
               end else begin
                  top = hi_h > 0 ? 0 : hi_h;
                  bot = lo_h < -rf ? -rf : lo_h;
                  num = 2 * rf * (top - lo_h) - (top - bot) * (2 * rf + top + bot);
                  if (num < 0) num = 0;
                  den  = 2 * rf * total;
                  k    = 255 * (df - m);
                  prod = 128'(k) * 128'(num);
                  q    = 64'(prod / 128'(den));
                  a    = (255 * m + q) / df;
               end
            end
         end
         if (a < 0) a = 0;
         if (a > 255) a = 255;
         return a[7:0];
      endfunction

      function void note_heights(logic signed [15:0] vh, logic signed [15:0] th);
         pending.push_back(fog_alpha_of(vh, th));
      endfunction

      function void check_alpha(logic [7:0] got);
         logic [7:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item, alpha %0d", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            $display("%0t: fog_alpha expected %0d actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [15:0] req_view_height = 0, req_target_height = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [7:0] rsp_fog_alpha;
   logic csr_valid = 0, csr_ready;
   logic [0:0] csr_index = CSR_RAMP_RANGE;
   logic [6:0] csr_data = 0;

   int send_idle_pct = 0, stall_pct = 0, hold_off = 0;
   alpha_scoreboard board = new();

   fog_height_crossing_fraction DUT (.*);

   always #6 clock = ~clock;

   // receiver side, with an optional long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_alpha(rsp_fog_alpha);
      if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [6:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_RAMP_RANGE) board.ramp_reg = val;
      else board.deep_reg = val;
   endtask

   task automatic send_heights(logic signed [15:0] vh, logic signed [15:0] th);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid         <= 1;
      req_view_height   <= vh;
      req_target_height <= th;
      do @(posedge clock); while (req_stall);
      board.note_heights(vh, th);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_height(int rr, int dd);
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 2 * dd * 256) - dd * 256);
         2: return 16'(-$urandom_range(0, rr * 256 + 300));
         3: return 16'($urandom_range(0, 600) - 300);
         default: return 16'($urandom_range(0, (dd + 2) * 256) - (dd + 1) * 256);
      endcase
   endfunction

   task automatic random_phase(int count);
      int rr, dd;
      logic signed [15:0] vh;
      rr = board.ramp_reg == 0 ? 1 : board.ramp_reg;
      dd = board.deep_reg == 0 ? 1 : board.deep_reg;
      repeat (count) begin
         vh = pick_height(rr, dd);
         if ($urandom_range(9) == 0) send_heights(vh, vh);
         else send_heights(vh, pick_height(rr, dd));
      end
   endtask

   initial begin
      logic signed [15:0] edges[];
      edges = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001, -16'sh0800,
                -16'sh0801, -16'sh1e00, -16'sh1dff};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, equal heights, boundaries of ramp and deep depth
      foreach (edges[i]) begin
         send_heights(edges[i], edges[i]);
         send_heights(edges[i], edges[(i + 1) % edges.size()]);
      end
      send_heights(16'sh0100, 16'sh0200);
      send_heights(-16'sh4000, -16'sh5000);
      drain();
      // back-pressure: long receiver hold-off while items keep coming
      hold_off = 60;
      random_phase(40);
      drain();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(CSR_RAMP_RANGE, 7'd1);   write_reg(CSR_DEEP_DEPTH, 7'd1);   end
            1: begin write_reg(CSR_RAMP_RANGE, 7'd127); write_reg(CSR_DEEP_DEPTH, 7'd127); end
            2: begin write_reg(CSR_RAMP_RANGE, 7'd0);   write_reg(CSR_DEEP_DEPTH, 7'd0);   end
            3: begin write_reg(CSR_RAMP_RANGE, 7'd127); write_reg(CSR_DEEP_DEPTH, 7'd1);   end
            default: begin
               write_reg(CSR_RAMP_RANGE, 7'($urandom_range(1, 127)));
               write_reg(CSR_DEEP_DEPTH, 7'($urandom_range(1, 127)));
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         random_phase(210);
         drain();
      end
      if (board.errors == 0 && board.pending.size() == 0)
         $display("fog_height_crossing_fraction regression: pass");
      else
         $display("fog_height_crossing_fraction regression: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("fog_height_crossing_fraction regression: fail");
      $finish;
   end

endmodule
